### src/oqod_pkg.sv
// Shared types, codes and helpers of the order queue with owner dequeue.
package oqod_pkg;

    // Default number of entries held in the queue.
    localparam int QUEUE_DEPTH_DEF = 16;
    // Most results one list request may produce.
    localparam int MAX_RESULTS = 16;
    localparam int K_W = $clog2(MAX_RESULTS + 1);

    // Order id counter value after reset.
    localparam logic [31:0] FIRST_ID_RST = 32'd1;

    // Request actions.
    typedef enum logic [1:0] {
        A_ENQ  = 2'd0,
        A_DEQ  = 2'd1,
        A_LIST = 2'd2,
        A_NONE = 2'd3
    } t_action;

    // Result codes.
    typedef enum logic [2:0] {
        C_ENQUEUED   = 3'd0,
        C_DISPATCHED = 3'd1,
        C_LISTED     = 3'd2,
        C_EMPTY      = 3'd3,
        C_NO_MATCH   = 3'd4,
        C_FULL       = 3'd5,
        C_NONE_FOUND = 3'd6
    } t_code;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // One stored order.
    typedef struct packed {
        logic [31:0] order_id;
        logic [15:0] buyer;
        logic [15:0] seller;
        logic [30:0] price;
        logic [15:0] detail;
    } t_entry;

    // Per-cell update controls.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    // One result as held in the output register.
    typedef struct packed {
        t_code       code;
        t_entry      entry;
        logic        last;
    } t_res;

    // Builds a result from a code, an entry and the last mark.
    function automatic t_res mk_res(t_code code, t_entry entry, logic last);
        t_res r;
        r.code  = code;
        r.entry = entry;
        r.last  = last;
        return r;
    endfunction

endpackage

### src/oqod_if.sv
// Handshake interfaces for the request, result and configuration channels.
interface oqod_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] buyer_id;
    logic [15:0] seller_id;
    logic [30:0] total_price;
    logic [15:0] detail_id;
    logic        is_admin;

    modport source (output valid, action, buyer_id, seller_id, total_price, detail_id,
                    is_admin, input ready);
    modport sink (input valid, action, buyer_id, seller_id, total_price, detail_id,
                  is_admin, output ready);
endinterface

interface oqod_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_code;
    logic [31:0] order_id;
    logic [15:0] out_buyer;
    logic [15:0] out_seller;
    logic [30:0] out_price;
    logic [15:0] out_detail;
    logic        last;

    modport source (output valid, result_code, order_id, out_buyer, out_seller, out_price,
                    out_detail, last, input ready);
    modport sink (input valid, result_code, order_id, out_buyer, out_seller, out_price,
                  out_detail, last, output ready);
endinterface

interface oqod_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### src/oqod_cell.sv
// One queue cell: holds an entry and takes its neighbour's entry or a new one.
module oqod_cell (
    input  logic                i_clk,
    input  oqod_pkg::t_cell_ctl i_ctl,
    input  oqod_pkg::t_entry    i_next,
    input  oqod_pkg::t_entry    i_new,
    output oqod_pkg::t_entry    o_entry
);
    import oqod_pkg::*;

    t_entry r_entry;

    // A new order is written at the tail; otherwise the cell takes its neighbour or holds.
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end else begin
            r_entry <= r_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

### src/order_queue_with_owner_dequeue_unit.sv
// Top level of the order queue: cell ring, scan sequencer and output register.
// Enqueue and any request that finds the queue empty: the result is registered in the cycle
// after the request is taken. Dequeue and list rotate the cell ring once in S_SCAN, holding
// while results stall, and register the last result in S_DONE (a list may push earlier ones
// during the scan); the next request is taken back in S_IDLE, one request at a time.
// Reset empties the queue, sets the id counter to 1 and clears the output valid flag.
module order_queue_with_owner_dequeue_unit #(
    parameter int QUEUE_DEPTH = oqod_pkg::QUEUE_DEPTH_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    oqod_cfg_if.sink    i_cfg,
    oqod_req_if.sink    i_req,
    oqod_res_if.source  o_res
);
    import oqod_pkg::*;

    localparam int IdxW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IdxW-1:0] LastStep = IdxW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);
    localparam logic [K_W-1:0] MaxK = K_W'(MAX_RESULTS);

    t_state          r_state, n_state;
    logic [CntW-1:0] r_count;
    logic [31:0]     r_next_id;
    logic [IdxW-1:0] r_step;
    logic [IdxW-1:0] r_pos;
    logic [K_W-1:0]  r_k;
    logic            r_pend_valid;
    logic            r_found;
    t_entry          r_pend;
    logic [15:0]     r_seller;
    logic            r_admin;
    t_action         r_act;
    logic            r_out_valid;
    t_res            r_out;

    t_entry          w_entry [QUEUE_DEPTH];
    t_cell_ctl       w_ctl [QUEUE_DEPTH];
    t_entry          w_new;
    t_entry          w_head;
    t_action         w_req_act;
    logic            w_out_free;
    logic            w_req_acc;
    logic            w_cfg_acc;
    logic            w_full;
    logic            w_match;
    logic            w_list_take;
    logic            w_deq_take;
    logic            c_rotate;
    logic            c_compact;
    logic            c_write;
    logic            c_out_load;
    t_res            w_out_next;

    // Handshake helpers.
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_req_acc  = i_req.valid && i_req.ready;
    assign w_cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign w_req_act  = t_action'(i_req.action);
    assign w_full     = (r_count == FullCnt);
    assign i_cfg.ready = 1'b1;

    // The new entry carries the next order id.
    always_comb begin
        w_new.order_id = r_next_id;
        w_new.buyer    = i_req.buyer_id;
        w_new.seller   = i_req.seller_id;
        w_new.price    = i_req.total_price;
        w_new.detail   = i_req.detail_id;
    end

    // The head cell shows the entry of age r_step while the ring rotates.
    assign w_head  = w_entry[0];
    assign w_match = (CntW'(r_step) < r_count) && (r_admin || (w_head.seller == r_seller));
    assign w_list_take = c_rotate && (r_act == A_LIST) && w_match && (r_k < MaxK);
    assign w_deq_take  = c_rotate && (r_act == A_DEQ) && w_match && !r_found;

    // Ring of cells: each takes its upper neighbour, the top one takes the head.
    for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
        t_entry w_next;
        if (j == QUEUE_DEPTH - 1) begin : g_top
            assign w_next = w_entry[0];
        end else begin : g_mid
            assign w_next = w_entry[j+1];
        end
        assign w_ctl[j].shift = c_rotate || (c_compact && (IdxW'(j) >= r_pos));
        assign w_ctl[j].load  = c_write && (r_count == CntW'(j));

        oqod_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[j]),
            .i_next  (w_next),
            .i_new   (w_new),
            .o_entry (w_entry[j])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc && (w_req_act == A_DEQ || w_req_act == A_LIST)
                    && (r_count != '0)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_out_free && (r_step == LastStep)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Controls and the next result.
    always_comb begin
        i_req.ready = (r_state == S_IDLE) && w_out_free;
        c_rotate    = (r_state == S_SCAN) && w_out_free;
        c_compact   = 1'b0;
        c_write     = 1'b0;
        c_out_load  = 1'b0;
        w_out_next  = mk_res(C_EMPTY, '0, 1'b1);
        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    unique case (w_req_act)
                        A_ENQ: begin
                            c_out_load = 1'b1;
                            if (w_full) begin
                                w_out_next = mk_res(C_FULL, '0, 1'b1);
                            end else begin
                                c_write    = 1'b1;
                                w_out_next = mk_res(C_ENQUEUED, w_new, 1'b1);
                            end
                        end
                        A_DEQ, A_LIST: begin
                            c_out_load = (r_count == '0);
                        end
                        default: c_out_load = 1'b0;
                    endcase
                end
            end
            S_SCAN: begin
                // A new match pushes the held one out, which is then not the last.
                if (w_list_take && r_pend_valid) begin
                    c_out_load = 1'b1;
                    w_out_next = mk_res(C_LISTED, r_pend, 1'b0);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    c_out_load = 1'b1;
                    if (r_act == A_LIST) begin
                        w_out_next = r_pend_valid ? mk_res(C_LISTED, r_pend, 1'b1)
                                                  : mk_res(C_NONE_FOUND, '0, 1'b1);
                    end else begin
                        c_compact  = r_found;
                        w_out_next = r_found ? mk_res(C_DISPATCHED, r_pend, 1'b1)
                                             : mk_res(C_NO_MATCH, '0, 1'b1);
                    end
                end
            end
            default: c_out_load = 1'b0;
        endcase
    end

    // Sequencer, counters and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_next_id    <= FIRST_ID_RST;
            r_out_valid  <= 1'b0;
            r_step       <= '0;
            r_k          <= '0;
            r_pend_valid <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            r_state <= n_state;

            // Id counter: a configuration write reloads it.
            if (w_cfg_acc) begin
                r_next_id <= i_cfg.data;
            end else if (c_write) begin
                r_next_id <= r_next_id + 32'd1;
            end

            // Occupancy.
            if (c_write) begin
                r_count <= r_count + CntW'(1);
            end else if (c_compact) begin
                r_count <= r_count - CntW'(1);
            end

            // Output register.
            if (c_out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= w_out_next;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            // Latch the match key when a request is taken.
            if (w_req_acc) begin
                r_act        <= w_req_act;
                r_seller     <= i_req.seller_id;
                r_admin      <= i_req.is_admin;
                r_step       <= '0;
                r_k          <= '0;
                r_pend_valid <= 1'b0;
                r_found      <= 1'b0;
            end

            // Scan step: one entry passes the head per rotation.
            if (c_rotate) begin
                r_step <= r_step + IdxW'(1);
            end
            if (w_list_take) begin
                r_pend       <= w_head;
                r_pend_valid <= 1'b1;
                r_k          <= r_k + K_W'(1);
            end
            if (w_deq_take) begin
                r_pend  <= w_head;
                r_found <= 1'b1;
                r_pos   <= r_step;
            end
        end
    end

    // Result channel.
    assign o_res.valid       = r_out_valid;
    assign o_res.result_code = r_out.code;
    assign o_res.order_id    = r_out.entry.order_id;
    assign o_res.out_buyer   = r_out.entry.buyer;
    assign o_res.out_seller  = r_out.entry.seller;
    assign o_res.out_price   = r_out.entry.price;
    assign o_res.out_detail  = r_out.entry.detail;
    assign o_res.last        = r_out.last;

`ifndef SYNTHESIS
    // Occupancy never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCnt)
        else $error("queue occupancy exceeds depth");

    // A stored order raises the occupancy by one.
    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_write |=> (r_count == $past(r_count) + CntW'(1)))
        else $error("enqueue did not raise occupancy");

    // A dispatch lowers the occupancy by one.
    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_compact |=> (r_count == $past(r_count) - CntW'(1)))
        else $error("dispatch did not lower occupancy");

    // The ring holds still while the result side stalls.
    a_scan_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !w_out_free) |=> $stable(r_step))
        else $error("scan advanced during a stall");

    // A list never captures more matches than it may report.
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= MaxK)
        else $error("list capture count out of range");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the order queue: directed requests, then random phases.
module tb_top;
    import oqod_pkg::*;

    localparam int QDEPTH      = QUEUE_DEPTH_DEF;
    // Quiet cycles after the last result, to cover a ring rotation that reports nothing.
    localparam int SETTLE      = 2 * QDEPTH + 8;
    localparam int PHASE_ITEMS = 87;
    // The result side pauses for a long stretch once, after this many results.
    localparam int HOLD_AT     = 120;
    localparam int LONG_HOLD   = 300;
    localparam int RUN_LIMIT   = 1000000;
    localparam int SHOW_MAX    = 30;

    typedef struct {
        t_action     action;
        logic [15:0] buyer;
        logic [15:0] seller;
        logic [30:0] price;
        logic [15:0] detail;
        logic        admin;
    } t_order_req;

    // One row of the directed plan; a typed row carries its single result by hand.
    typedef struct {
        int          reps;
        t_order_req  req;
        bit          typed;
        t_code       code;
        logic [31:0] id;
    } t_step;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count = 0;
    bit   calm = 1'b0;

    int n_errors   = 0;
    int n_results  = 0;
    int n_accepted = 0;
    int n_random   = 0;
    int n_full     = 0;
    int n_settings = 0;

    // Predicted queue contents and id counter.
    t_entry      order_book[$];
    logic [31:0] book_next_id;
    t_res        fresh[$];
    t_res        due_results[$];
    t_step       plan[$];

    oqod_req_if req_if();
    oqod_res_if res_if();
    oqod_cfg_if cfg_if();

    order_queue_with_owner_dequeue_unit #(
        .QUEUE_DEPTH(QDEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Works out the results of one request and updates the predicted queue.
    function automatic void predict_order(input t_order_req r);
        t_res   rec;
        t_entry e;
        int     hit;
        fresh.delete();
        rec      = '0;
        rec.last = 1'b1;
        hit      = -1;
        case (r.action)
            A_ENQ: begin
                if (order_book.size() >= QDEPTH) begin
                    rec.code = C_FULL;
                    n_full++;
                end else begin
                    e.order_id = book_next_id;
                    e.buyer    = r.buyer;
                    e.seller   = r.seller;
                    e.price    = r.price;
                    e.detail   = r.detail;
                    order_book.push_back(e);
                    book_next_id = book_next_id + 32'd1;
                    rec.code  = C_ENQUEUED;
                    rec.entry = e;
                end
                fresh.push_back(rec);
            end
            A_DEQ: begin
                foreach (order_book[i]) begin
                    if (hit < 0 && (r.admin || order_book[i].seller == r.seller))
                        hit = i;
                end
                if (order_book.size() == 0) begin
                    rec.code = C_EMPTY;
                end else if (hit < 0) begin
                    rec.code = C_NO_MATCH;
                end else begin
                    rec.code  = C_DISPATCHED;
                    rec.entry = order_book[hit];
                    order_book.delete(hit);
                end
                fresh.push_back(rec);
            end
            A_LIST: begin
                if (order_book.size() == 0) begin
                    rec.code = C_EMPTY;
                    fresh.push_back(rec);
                end else begin
                    rec.code = C_LISTED;
                    rec.last = 1'b0;
                    foreach (order_book[i]) begin
                        if (fresh.size() < MAX_RESULTS &&
                            (r.admin || order_book[i].seller == r.seller)) begin
                            rec.entry = order_book[i];
                            fresh.push_back(rec);
                        end
                    end
                    if (fresh.size() == 0) begin
                        rec      = '0;
                        rec.code = C_NONE_FOUND;
                        rec.last = 1'b1;
                        fresh.push_back(rec);
                    end else begin
                        fresh[fresh.size() - 1].last = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int draw_pause();
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic void add_step(input int reps, input t_action action,
                                     input logic [15:0] buyer, input logic [15:0] seller,
                                     input logic [30:0] price, input logic [15:0] detail,
                                     input logic admin, input bit typed, input t_code code,
                                     input logic [31:0] id);
        t_step s;
        s.reps       = reps;
        s.req.action = action;
        s.req.buyer  = buyer;
        s.req.seller = seller;
        s.req.price  = price;
        s.req.detail = detail;
        s.req.admin  = admin;
        s.typed      = typed;
        s.code       = code;
        s.id         = id;
        plan.push_back(s);
    endfunction

    // Random request; sellers mostly come from a small pool so that matches happen.
    function automatic t_order_req random_order(input int enq_pct);
        t_order_req r;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            r.action = A_NONE;
        else if (roll < 3 + enq_pct)
            r.action = A_ENQ;
        else if ($urandom_range(0, 4) < 3)
            r.action = A_DEQ;
        else
            r.action = A_LIST;
        r.buyer  = 16'($urandom);
        r.seller = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        r.price  = 31'($urandom);
        r.detail = 16'($urandom);
        r.admin  = ($urandom_range(0, 4) == 0);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= SHOW_MAX)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Offers one request after a random gap and records what it should produce.
    task automatic offer_order(input t_order_req r, input bit typed, input t_res typed_res);
        int gap;
        gap = draw_pause();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.action      <= r.action;
        req_if.buyer_id    <= r.buyer;
        req_if.seller_id   <= r.seller;
        req_if.total_price <= r.price;
        req_if.detail_id   <= r.detail;
        req_if.is_admin    <= r.admin;
        do @(posedge i_clk); while (!req_if.ready);
        n_accepted++;
        predict_order(r);
        if (typed) begin
            due_results.push_back(typed_res);
        end else begin
            foreach (fresh[i])
                due_results.push_back(fresh[i]);
        end
    endtask

    // Waits for the queue to drain, then loads a new first order id.
    task automatic load_first_id(input logic [31:0] value);
        req_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        book_next_id = value;
        n_settings++;
    endtask

    // Result side: random pauses, one long hold, and a check of every result.
    initial begin : result_side
        t_res want;
        int   stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        res_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                n_results++;
                if (due_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= SHOW_MAX)
                        $display("%0t: unexpected result, code %0d order id %0h", $time,
                                 res_if.result_code, res_if.order_id);
                end else begin
                    want = due_results.pop_front();
                    check_field("result_code", 32'(want.code), 32'(res_if.result_code));
                    check_field("order_id", want.entry.order_id, res_if.order_id);
                    check_field("out_buyer", 32'(want.entry.buyer), 32'(res_if.out_buyer));
                    check_field("out_seller", 32'(want.entry.seller), 32'(res_if.out_seller));
                    check_field("out_price", 32'(want.entry.price), 32'(res_if.out_price));
                    check_field("out_detail", 32'(want.entry.detail), 32'(res_if.out_detail));
                    check_field("last", 32'(want.last), 32'(res_if.last));
                end
                stall_left = (n_results == HOLD_AT) ? LONG_HOLD : draw_pause();
                if (stall_left > 0)
                    res_if.ready <= 1'b0;
            end else if (!res_if.ready) begin
                stall_left--;
                if (stall_left <= 0)
                    res_if.ready <= 1'b1;
            end
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) @(posedge i_clk);
        $display("tb_top: FAIL");
        $finish;
    end

    // Request side: reset, directed plan, then random phases under several id settings.
    initial begin : stimulus
        t_order_req  r;
        t_res        typed_res;
        logic [31:0] id_setting [5];
        int          enq_share [5];
        int          made;

        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.action      <= A_NONE;
        req_if.buyer_id    <= '0;
        req_if.seller_id   <= '0;
        req_if.total_price <= '0;
        req_if.detail_id   <= '0;
        req_if.is_admin    <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.data        <= '0;
        book_next_id = FIRST_ID_RST;

        // Empty queue, unused action, field extremes, filling to full, full-length
        // list, no match on list and dequeue, removal from the middle and admin removal.
        add_step(1, A_DEQ, 16'h0, 16'h0, 31'h0, 16'h0, 1'b0, 1, C_EMPTY, 32'd0);
        add_step(1, A_LIST, 16'h0, 16'hFFFF, 31'h0, 16'h0, 1'b1, 1, C_EMPTY, 32'd0);
        add_step(1, A_NONE, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF, 1'b1, 0,
                 C_EMPTY, 32'd0);
        add_step(1, A_ENQ, 16'h0, 16'h0, 31'h0, 16'h0, 1'b0, 1, C_ENQUEUED, 32'd1);
        add_step(1, A_ENQ, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF, 1'b1, 1,
                 C_ENQUEUED, 32'd2);
        add_step(14, A_ENQ, 16'd100, 16'd5, 31'd1000, 16'd200, 1'b0, 0, C_ENQUEUED, 32'd0);
        add_step(1, A_ENQ, 16'd1, 16'd2, 31'd3, 16'd4, 1'b0, 1, C_FULL, 32'd0);
        add_step(1, A_LIST, 16'h0, 16'h0, 31'h0, 16'h0, 1'b1, 0, C_LISTED, 32'd0);
        add_step(1, A_LIST, 16'h0, 16'd77, 31'h0, 16'h0, 1'b0, 1, C_NONE_FOUND, 32'd0);
        add_step(1, A_DEQ, 16'h0, 16'd77, 31'h0, 16'h0, 1'b0, 1, C_NO_MATCH, 32'd0);
        add_step(1, A_DEQ, 16'h0, 16'd6, 31'h0, 16'h0, 1'b0, 0, C_DISPATCHED, 32'd0);
        add_step(1, A_LIST, 16'h0, 16'd7, 31'h0, 16'h0, 1'b0, 0, C_LISTED, 32'd0);
        add_step(1, A_DEQ, 16'h0, 16'd0, 31'h0, 16'h0, 1'b1, 0, C_DISPATCHED, 32'd0);
        add_step(1, A_DEQ, 16'h0, 16'hFFFF, 31'h0, 16'h0, 1'b0, 0, C_DISPATCHED, 32'd0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Repeated rows step the record fields and cycle the seller through three values.
        foreach (plan[s]) begin
            for (int k = 0; k < plan[s].reps; k++) begin
                r        = plan[s].req;
                r.buyer  = r.buyer + 16'(k);
                r.seller = r.seller + 16'(k % 3);
                r.price  = r.price + 31'(k);
                r.detail = r.detail + 16'(k);
                typed_res      = '0;
                typed_res.code = plan[s].code;
                typed_res.last = 1'b1;
                if (plan[s].code == C_ENQUEUED)
                    typed_res.entry = '{plan[s].id, r.buyer, r.seller, r.price, r.detail};
                offer_order(r, plan[s].typed, typed_res);
            end
        end

        // Id settings include wrap-around through zero and both extremes.
        id_setting = '{32'hFFFF_FFFD, 32'h0000_0000, $urandom, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
        enq_share  = '{70, 35, 55, 85, 45};
        for (int p = 0; p < 5; p++) begin
            load_first_id(id_setting[p]);
            calm = (p == 2);
            made = 0;
            while (made < PHASE_ITEMS) begin
                r = random_order(enq_share[p]);
                offer_order(r, 1'b0, '0);
                n_random++;
                if (r.action != A_NONE)
                    made++;
            end
        end
        calm = 1'b0;

        req_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Run covered %0d requests (%0d random) and %0d results under %0d id settings.",
                 n_accepted, n_random, n_results, n_settings + 1);
        $display("The queue was found full on %0d enqueue requests.", n_full);
        if (n_errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

### order_queue_with_owner_dequeue_unit.f
src/oqod_pkg.sv
src/oqod_if.sv
src/oqod_cell.sv
src/order_queue_with_owner_dequeue_unit.sv
tb/sv/tb_top.sv
